/* hw/rtl/sorted_key_floor_search_assert.svh */
// Assertion macros for the RTL file that checks itself.
`ifndef SORTED_KEY_FLOOR_SEARCH_ASSERT_SVH
`define SORTED_KEY_FLOOR_SEARCH_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SKFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skfs: same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define SKFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skfs: next-cycle check failed");

`endif

/* hw/rtl/skfs_pkg.sv */
package skfs_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int KEY_W       = 31;
	localparam int REQ_W       = 3;
	localparam int STAT_W      = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR       = 3'd0,
		REQ_APPEND      = 3'd1,
		REQ_FLOOR       = 3'd2,
		REQ_FLOOR_AFTER = 3'd3,
		REQ_NEXT        = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NOT_ABOVE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_NEXT,
		S_DONE
	} state_t;

	// Key memory write port
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [KEY_W-1:0] data;
	} mem_wr_t;

	// Key memory read port
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

	// Search launch command
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] first;
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] bound;
	} srch_cmd_t;

	// Search outcome, valid for one cycle with done
	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
	} srch_res_t;

endpackage

/* hw/rtl/skfs_keymem.sv */
module skfs_keymem
	import skfs_pkg::*;
(
	input  logic             clk,
	input  mem_wr_t          wr,
	input  mem_rd_t          rd,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem [MAX_ENTRIES];
	logic [KEY_W-1:0] rd_data_q;

	// Write one key, read one key with registered data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/skfs_search.sv */
module skfs_search
	import skfs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  srch_cmd_t        cmd,
	input  logic [KEY_W-1:0] rd_data,
	output mem_rd_t          rd,
	output srch_res_t        res
);

	logic             busy_q;
	logic [CNT_W-1:0] lo_q, hi_q, mid_q;
	logic [KEY_W-1:0] bound_q;
	logic             hit_q;
	logic [KEY_W-1:0] hit_key_q;
	logic             res_done_q;
	logic             res_found_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [KEY_W-1:0] res_key_q;

	logic             le;
	logic [CNT_W-1:0] lo_n, hi_n, lo_c, hi_c, mid_c, span;
	logic             issue, fin, found_c;
	logic [CNT_W-1:0] idx_c;

	// Compare the key read last cycle and narrow the range
	always_comb begin
		le    = (rd_data <= bound_q);
		lo_n  = le ? (mid_q + CNT_W'(1)) : lo_q;
		hi_n  = le ? hi_q : mid_q;
		lo_c  = cmd.start ? cmd.first : lo_n;
		hi_c  = cmd.start ? cmd.count : hi_n;
		span  = hi_c - lo_c;
		mid_c = lo_c + (span >> 1);
		issue = (cmd.start || busy_q) && (lo_c < hi_c);
		fin   = (cmd.start || busy_q) && !issue;
		found_c = busy_q && (hit_q || le);
		idx_c   = lo_c - CNT_W'(1);
	end

	assign rd.en   = issue;
	assign rd.addr = mid_c[IDX_W-1:0];

	// Control state of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			res_done_q <= 1'b0;
		end else begin
			busy_q     <= issue;
			res_done_q <= fin;
		end
	end

	// Range, best hit and outcome
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bound_q <= cmd.bound;
			hit_q   <= 1'b0;
		end else if (busy_q && le) begin
			hit_q     <= 1'b1;
			hit_key_q <= rd_data;
		end
		if (cmd.start || busy_q) begin
			lo_q  <= lo_c;
			hi_q  <= hi_c;
			mid_q <= mid_c;
		end
		if (fin) begin
			res_found_q <= found_c;
			res_idx_q   <= found_c ? idx_c[IDX_W-1:0] : '0;
			res_key_q   <= found_c ? (le ? rd_data : hit_key_q) : '0;
		end
	end

	// Present the outcome
	always_comb begin
		res.done  = res_done_q;
		res.found = res_found_q;
		res.idx   = res_idx_q;
		res.key   = res_key_q;
	end

endmodule

/* hw/rtl/sorted_key_floor_search.sv */
// Sorted key floor search: a table of up to 1024 strictly increasing 31-bit keys.
// Requests come in on the s_ channel (tuser = request kind, tdata = key and base
// index); each request gives exactly one result transaction on the m_ channel
// (tuser = found flag and status, tdata = entry index and key).
// Clear and append take effect when the request is accepted and answer through
// the S_DONE state. Next entry does one key read in state S_NEXT, or goes
// straight to S_DONE when there is no next entry.
// Floor searches run a binary search with one compare unit over the key
// memory, one memory read and one compare per cycle.
// The block takes one request at a time; s_tready stays low while a request is
// in work. A finished result sits in the output register until m_tready; the
// next request may be accepted meanwhile, but its result waits in the block
// until the output register is free.
// Reset empties the table (entry count zero) and drops any pending result.
// Key memory contents are not reset; entries beyond the count are never read.
`include "sorted_key_floor_search_assert.svh"

module sorted_key_floor_search
	import skfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [30:0] key, [40:31] base_index, [47:41] zero
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [9:0] entry_index, [40:10] key_value, [47:41] zero
	output logic [2:0]  m_tuser    // [0] found, [2:1] status
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [KEY_W-1:0] last_key_q;

	logic             res_found_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [KEY_W-1:0] res_key_q;
	status_t          res_status_q;

	logic             out_valid_q;
	logic             out_found_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [KEY_W-1:0] out_key_q;
	status_t          out_status_q;

	logic             accept, out_free;
	req_t             req;
	logic [KEY_W-1:0] in_key;
	logic [IDX_W-1:0] in_base;
	logic [CNT_W-1:0] base_p1;
	logic             next_ok;
	status_t          app_status;

	srch_cmd_t        srch_cmd;
	srch_res_t        srch_res;
	mem_rd_t          srch_rd, next_rd, mem_rd;
	mem_wr_t          mem_wr;
	logic [KEY_W-1:0] mem_rd_data;

	// Unpack the request
	always_comb begin
		req      = req_t'(s_tuser);
		in_key   = s_tdata[KEY_W-1:0];
		in_base  = s_tdata[KEY_W+IDX_W-1:KEY_W];
		base_p1  = {1'b0, in_base} + CNT_W'(1);
		next_ok  = (base_p1 < count_q);
		out_free = !out_valid_q || m_tready;
		accept   = s_tvalid && s_tready;
	end

	// Judge an append against the table
	always_comb begin
		if (count_q == CNT_W'(MAX_ENTRIES)) begin
			app_status = STAT_FULL;
		end else if ((count_q != '0) && (in_key <= last_key_q)) begin
			app_status = STAT_NOT_ABOVE;
		end else begin
			app_status = STAT_OK;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req) inside
						REQ_FLOOR, REQ_FLOOR_AFTER: state_d = S_SEARCH;
						REQ_NEXT:                   state_d = next_ok ? S_NEXT : S_DONE;
						default:                    state_d = S_DONE;
					endcase
				end
			end
			S_SEARCH: begin
				if (srch_res.done) begin
					state_d = S_DONE;
				end
			end
			S_NEXT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, search launch, memory ports
	always_comb begin
		s_tready       = (state_q == S_IDLE);
		srch_cmd.start = accept && ((req == REQ_FLOOR) || (req == REQ_FLOOR_AFTER));
		srch_cmd.first = (req == REQ_FLOOR_AFTER) ? base_p1 : '0;
		srch_cmd.count = count_q;
		srch_cmd.bound = in_key;
		next_rd.en     = accept && (req == REQ_NEXT) && next_ok;
		next_rd.addr   = base_p1[IDX_W-1:0];
		mem_rd         = srch_rd.en ? srch_rd : next_rd;
		mem_wr.en      = accept && (req == REQ_APPEND) && (app_status == STAT_OK);
		mem_wr.addr    = count_q[IDX_W-1:0];
		mem_wr.data    = in_key;
	end

	skfs_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (srch_cmd),
		.rd_data (mem_rd_data),
		.rd      (srch_rd),
		.res     (srch_res)
	);

	skfs_keymem u_keymem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (mem_rd_data)
	);

	// Control registers: state, table count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (req == REQ_CLEAR)) begin
				count_q <= '0;
			end else if (mem_wr.en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result staging and output register
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			last_key_q <= in_key;
		end
		if (accept) begin
			res_found_q  <= 1'b0;
			res_idx_q    <= (req == REQ_NEXT) ? base_p1[IDX_W-1:0] : '0;
			res_key_q    <= '0;
			res_status_q <= (req == REQ_APPEND) ? app_status : STAT_OK;
		end else if ((state_q == S_SEARCH) && srch_res.done) begin
			res_found_q <= srch_res.found;
			res_idx_q   <= srch_res.idx;
			res_key_q   <= srch_res.key;
		end else if (state_q == S_NEXT) begin
			res_found_q <= 1'b1;
			res_key_q   <= mem_rd_data;
		end
		if ((state_q == S_DONE) && out_free) begin
			out_found_q  <= res_found_q;
			out_idx_q    <= (state_q == S_DONE && !res_found_q) ? '0 : res_idx_q;
			out_key_q    <= res_key_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_key_q, out_idx_q};
	assign m_tuser  = {out_status_q, out_found_q};

	// Checks on the sequencer and search unit
	`SKFS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_ENTRIES))
	`SKFS_ASSERT_IMP(a_done_in_search, clk, arst_n, srch_res.done, state_q == S_SEARCH)
	`SKFS_ASSERT_IMP(a_hit_in_table, clk, arst_n, srch_res.done && srch_res.found,
		CNT_W'(srch_res.idx) < count_q)
	`SKFS_ASSERT_NEXT(a_result_posted, clk, arst_n, (state_q == S_DONE) && out_free,
		m_tvalid && s_tready)

endmodule

/* tb/sv/tb_sorted_key_floor_search.sv */
module tb_sorted_key_floor_search;
	import skfs_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFFFFFF;
	localparam int RANDOM_ITEMS = 200;

	// One result transaction, as the block reports it
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [KEY_W-1:0]  kv;
		logic [STAT_W-1:0] status;
	} answer_t;

	// One row of the directed table; typed rows carry their own answer
	typedef struct {
		logic [REQ_W-1:0] req;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] base;
		bit               typed;
		answer_t          ans;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [30:0] key, [40:31] base_index, [47:41] zero
	logic [2:0]  s_tuser;   // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // [9:0] entry_index, [40:10] key_value, [47:41] zero
	logic [2:0]  m_tuser;   // [0] found, [2:1] status

	// Shadow copy of the key table
	logic [KEY_W-1:0] tbl_keys [MAX_ENTRIES];
	int               tbl_count = 0;

	answer_t  pending_answers[$];
	dir_row_t directed_rows[$];
	int       fail_count = 0;
	bit       no_stall = 1'b0;

	sorted_key_floor_search DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

	// Largest entry at or after first whose key does not exceed bound
	function automatic answer_t lookup_floor(int first, logic [KEY_W-1:0] bound);
		answer_t a;
		a = '0;
		for (int i = tbl_count - 1; i >= first && !a.found; i--) begin
			if (tbl_keys[i] <= bound) begin
				a.found = 1'b1;
				a.idx   = i[IDX_W-1:0];
				a.kv    = tbl_keys[i];
			end
		end
		return a;
	endfunction

	// Apply one request to the shadow table and return its answer
	function automatic answer_t predict_answer(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
		logic [IDX_W-1:0] base);
		answer_t a;
		a = '0;
		case (req)
			REQ_CLEAR: begin
				tbl_count = 0;
			end
			REQ_APPEND: begin
				if (tbl_count >= MAX_ENTRIES) begin
					a.status = STAT_FULL;
				end else if (tbl_count > 0 && key <= tbl_keys[tbl_count-1]) begin
					a.status = STAT_NOT_ABOVE;
				end else begin
					tbl_keys[tbl_count] = key;
					tbl_count++;
				end
			end
			REQ_FLOOR: begin
				a = lookup_floor(0, key);
			end
			REQ_FLOOR_AFTER: begin
				a = lookup_floor(int'(base) + 1, key);
			end
			REQ_NEXT: begin
				if (int'(base) + 1 < tbl_count) begin
					a.found = 1'b1;
					a.idx   = base + IDX_W'(1);
					a.kv    = tbl_keys[int'(base) + 1];
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	// Drive one request from a falling edge; return at the falling edge after acceptance
	task automatic send_req(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
		logic [IDX_W-1:0] base, bit typed, answer_t lit);
		answer_t a;
		while (!no_stall && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {7'd0, base, key};
		do @(posedge clk); while (!s_tready);
		a = predict_answer(req, key, base);
		pending_answers.push_back(typed ? lit : a);
		@(negedge clk);
	endtask

	task automatic add_row(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
		logic [IDX_W-1:0] base, bit typed, logic found, logic [IDX_W-1:0] idx,
		logic [KEY_W-1:0] kv, logic [STAT_W-1:0] status);
		dir_row_t r;
		r.req  = req;
		r.key  = key;
		r.base = base;
		r.typed = typed;
		r.ans  = '{found, idx, kv, status};
		directed_rows.push_back(r);
	endtask

	// Stall the result side at random
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= no_stall || ($urandom_range(0, 99) >= 12);
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		answer_t want;
		answer_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.found  = m_tuser[0];
			got.status = m_tuser[2:1];
			got.idx    = m_tdata[9:0];
			got.kv     = m_tdata[40:10];
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result found=%0d idx=%0d key=%h status=%0d",
					$time, got.found, got.idx, got.kv, got.status);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected found=%0d idx=%0d key=%h status=%0d",
						$time, want.found, want.idx, want.kv, want.status);
					$display("%0t:          actual   found=%0d idx=%0d key=%h status=%0d",
						$time, got.found, got.idx, got.kv, got.status);
					fail_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int               roll;
		int               span;
		int               pick;
		int               hi;
		logic [31:0]      cand;
		logic [REQ_W-1:0] req;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] base;
		dir_row_t         row;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;

		// Empty table lookups, append ordering, extremes, unused codes, clear
		add_row(REQ_FLOOR,       KEY_MAX,   10'd0,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_NEXT,        31'd0,     10'd0,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_FLOOR_AFTER, KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_APPEND,      31'd0,     10'd0,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_APPEND,      31'd0,     10'd0,    1, 0, 10'd0, 31'd0,   STAT_NOT_ABOVE);
		add_row(REQ_APPEND,      KEY_MAX,   10'd0,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_APPEND,      KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_NOT_ABOVE);
		add_row(REQ_FLOOR,       31'd0,     10'd0,    1, 1, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_FLOOR,       KEY_MAX,   10'd0,    1, 1, 10'd1, KEY_MAX, STAT_OK);
		add_row(REQ_FLOOR_AFTER, KEY_MAX,   10'd0,    1, 1, 10'd1, KEY_MAX, STAT_OK);
		add_row(REQ_FLOOR_AFTER, KEY_MAX,   10'd1,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_FLOOR_AFTER, KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_NEXT,        KEY_MAX,   10'd0,    1, 1, 10'd1, KEY_MAX, STAT_OK);
		add_row(REQ_NEXT,        31'd0,     10'd1,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_NEXT,        KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(3'd5,            KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(3'd6,            31'd0,     10'd0,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(3'd7,            KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_CLEAR,       KEY_MAX,   10'd1023, 1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_FLOOR,       KEY_MAX,   10'd0,    1, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_APPEND,      31'h2AAAAAAA, 10'h155, 1, 0, 10'd0, 31'd0, STAT_OK);
		add_row(REQ_APPEND,      31'h55555555, 10'h2AA, 1, 0, 10'd0, 31'd0, STAT_OK);
		add_row(REQ_FLOOR,       31'h55555554, 10'd0, 0, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_FLOOR_AFTER, 31'h55555555, 10'd0, 0, 0, 10'd0, 31'd0,   STAT_OK);
		add_row(REQ_APPEND,      31'h40000000, 10'd0, 1, 0, 10'd0, 31'd0,   STAT_NOT_ABOVE);

		// Hold reset, then release between edges
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_req(row.req, row.key, row.base, row.typed, row.ans);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_stall = (n >= 30 && n < 110);

			// Fill the table to capacity once, then probe the full table
			if (n == 120) begin
				send_req(REQ_CLEAR, KEY_W'($urandom), IDX_W'($urandom), 1'b0, '0);
				cand = $urandom_range(0, 32'h1FFFFF);
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					send_req(REQ_APPEND, cand[KEY_W-1:0], IDX_W'($urandom), 1'b0, '0);
					cand = cand + $urandom_range(1, 32'h1FFFFF);
				end
				send_req(REQ_APPEND, KEY_MAX, IDX_W'($urandom), 1'b0, '0);
				send_req(REQ_APPEND, 31'd0, IDX_W'($urandom), 1'b0, '0);
				send_req(REQ_APPEND, KEY_W'($urandom), IDX_W'($urandom), 1'b0, '0);
			end

			roll = $urandom_range(0, 99);
			key  = KEY_W'($urandom);
			base = IDX_W'($urandom);
			if (roll < 3 && !(n > 120 && n < 180)) begin
				req = REQ_CLEAR;
			end else if (roll < 6) begin
				req = REQ_W'($urandom_range(5, 7));
			end else if (roll < 36) begin
				// Well-formed append: above the last key where it can be, clamped at KEY_MAX
				req = REQ_APPEND;
				if (tbl_count == 0) begin
					key = KEY_W'(($urandom_range(0, 3) == 0) ? $urandom
						: $urandom_range(0, 1000));
				end else begin
					pick = $urandom_range(0, 3);
					span = (pick == 0) ? 1 : (pick == 1) ? 16 : (pick == 2) ? 32'hFFFF
						: 32'h3FFFFFF;
					cand = {1'b0, tbl_keys[tbl_count-1]} + $urandom_range(1, span);
					if (cand > {1'b0, KEY_MAX})
						cand = {1'b0, KEY_MAX};
					key = cand[KEY_W-1:0];
				end
			end else if (roll < 42) begin
				// Broken append: repeat or undercut a stored key
				req = REQ_APPEND;
				if (tbl_count > 0)
					key = tbl_keys[$urandom_range(0, tbl_count - 1)];
			end else begin
				req = REQ_W'($urandom_range(REQ_FLOOR, REQ_NEXT));
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					key = 31'd0;
				end else if (pick == 1) begin
					key = KEY_MAX;
				end else if (pick >= 4 && tbl_count > 0) begin
					key = tbl_keys[$urandom_range(0, tbl_count - 1)];
					if (pick == 5 && key != 31'd0)
						key = key - KEY_W'(1);
					else if (pick == 6 && key != KEY_MAX)
						key = key + KEY_W'(1);
				end
				if ($urandom_range(0, 9) < 8) begin
					hi = (tbl_count + 1 > MAX_ENTRIES - 1) ? MAX_ENTRIES - 1 : tbl_count + 1;
					base = IDX_W'($urandom_range(0, hi));
				end
			end
			send_req(req, key, base, 1'b0, '0);
		end

		// Drain outstanding results, then allow for stray ones
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
